// ===== rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, segment font and control store for the seven-segment shift driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int DIGITS_DEFAULT = 4;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7E;
  localparam logic [7:0] DP_MASK    = 8'h80;
  localparam int         FONT_SIZE  = 95;

  localparam logic [7:0] SEG_FONT [FONT_SIZE] = '{
    8'h00, 8'h82, 8'hA2, 8'h5C, 8'h6D, 8'h00, 8'h7F, 8'h02,
    8'h39, 8'h0F, 8'h00, 8'h00, 8'h04, 8'h40, 8'h00, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h48, 8'h48, 8'h58, 8'h48, 8'h4C, 8'h53, 8'h7B,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76,
    8'h06, 8'h1E, 8'h7A, 8'h38, 8'h37, 8'h54, 8'h3F, 8'h73,
    8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h3E, 8'h3E, 8'h76,
    8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08, 8'h60,
    8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h6F, 8'h74,
    8'h04, 8'h1E, 8'h7A, 8'h06, 8'h37, 8'h54, 8'h5C, 8'h73,
    8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1C, 8'h1C, 8'h76,
    8'h6E, 8'h5B, 8'h39, 8'h30, 8'h0F, 8'h62
  };

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_LOAD   = 3'd1,
    S_SHIFT  = 3'd2,
    S_NEXT   = 3'd3,
    S_STROBE = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    COND_ALWAYS     = 2'd0,
    COND_FLUSH      = 2'd1,
    COND_BIT_LAST   = 2'd2,
    COND_DIGIT_ZERO = 2'd3
  } cond_t;

  typedef struct packed {
    logic  take;
    logic  load;
    logic  emit;
    logic  strobe;
    logic  dec_digit;
    cond_t cond;
    step_t target;
    step_t alt;
  } uword_t;

  function automatic logic [7:0] glyph_of(input logic [7:0] code);
    logic [7:0] idx;
    idx = code - CODE_FIRST;
    if (code >= CODE_FIRST && code <= CODE_LAST) begin
      return SEG_FONT[idx[6:0]];
    end
    return 8'h00;
  endfunction

  // control store: take load emit strobe dec cond target alt
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      S_IDLE:   w = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, COND_FLUSH,      S_LOAD,   S_IDLE};
      S_LOAD:   w = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_ALWAYS,     S_SHIFT,  S_SHIFT};
      S_SHIFT:  w = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_BIT_LAST,   S_NEXT,   S_SHIFT};
      S_NEXT:   w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, COND_DIGIT_ZERO, S_STROBE, S_LOAD};
      S_STROBE: w = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, COND_ALWAYS,     S_IDLE,   S_IDLE};
      default:  w = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,     S_IDLE,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ssd_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_cmd_if
// Command channel: write a digit or flush the buffer.
// ----------------------------------------------------------------------------
interface ssd_cmd_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] position;
  logic [7:0] character;
  logic       decimal_point;

  modport source (output valid, action, position, character, decimal_point, input ready);
  modport sink   (input valid, action, position, character, decimal_point, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssd_bit_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_bit_if
// Serial bit channel toward the shift-register chain.
// ----------------------------------------------------------------------------
interface ssd_bit_if;
  logic valid;
  logic ready;
  logic serial_data;
  logic strobe_res;
  logic last;

  modport source (output valid, serial_data, strobe_res, last, input ready);
  modport sink   (input valid, serial_data, strobe_res, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/seven_segment_shift_display_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_shift_display_top
// Seven-segment digit buffer shifted out to a cascaded shift-register chain.
//
// cmd  : valid/ready command channel. action 0 writes one digit (font lookup,
//        decimal point on bit 7, stored active low); position >= DIGITS is
//        dropped. action 1 flushes the buffer when it is dirty.
// bits : valid/ready bit channel, one transfer per chain bit, last digit
//        first and MSB first, then one strobe transfer with last set.
// A control-store sequencer runs a dirty flush: one load step, eight shift
// steps and one digit step per digit, plus the accept and strobe steps. After
// the flush transfer the sequencer passes the load step, and the first bit is
// registered in the first shift step; a clean flush returns no transfers.
// cmd.ready is high only in the idle step.
// A stalled receiver holds the output register and freezes the step counter.
// Reset clears the buffer to zero and marks it dirty.
// ----------------------------------------------------------------------------
module seven_segment_shift_display_top
  import ssd_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  ssd_cmd_if.sink     cmd,
  ssd_bit_if.source   bits
);

  localparam int         DW       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [7:0] DIGITS_B = 8'(DIGITS);
  localparam logic [DW-1:0] DIGIT_TOP = DW'(DIGITS - 1);

  logic [7:0]    buffer [DIGITS];
  logic          dirty;
  logic [7:0]    shreg;
  logic [2:0]    bit_cnt;
  logic [DW-1:0] digit;

  step_t  step, step_next;
  uword_t uw;

  logic out_valid, out_data, out_strobe;
  logic out_free, stall, cond_true, cmd_xfer, do_flush, do_write;
  logic [7:0] stored;

  assign uw        = ucode(step);
  assign cmd.ready = uw.take;
  assign cmd_xfer  = cmd.valid && uw.take;
  assign do_flush  = cmd_xfer && (cmd.action == ACT_FLUSH) && dirty;
  assign do_write  = cmd_xfer && (cmd.action == ACT_WRITE) && (cmd.position < DIGITS_B);
  assign out_free  = !out_valid || bits.ready;
  assign stall     = uw.emit && !out_free;
  assign stored    = ~(glyph_of(cmd.character) | (cmd.decimal_point ? DP_MASK : 8'h00));

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_FLUSH:      cond_true = do_flush;
      COND_BIT_LAST:   cond_true = (bit_cnt == 3'd0);
      COND_DIGIT_ZERO: cond_true = (digit == '0);
      default:         cond_true = 1'b1;
    endcase
    if (stall) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = uw.target;
    end else begin
      step_next = uw.alt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) begin
        buffer[i] <= 8'h00;
      end
      dirty <= 1'b1;
    end else if (do_write) begin
      buffer[cmd.position[DW-1:0]] <= stored;
      if (buffer[cmd.position[DW-1:0]] != stored) begin
        dirty <= 1'b1;
      end
    end else if (do_flush) begin
      dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_flush) begin
      digit <= DIGIT_TOP;
    end else if (uw.dec_digit && digit != '0) begin
      digit <= digit - DW'(1);
    end
    if (uw.load) begin
      shreg   <= buffer[digit];
      bit_cnt <= 3'd7;
    end else if (uw.emit && !uw.strobe && !stall) begin
      shreg   <= {shreg[6:0], 1'b0};
      bit_cnt <= bit_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (bits.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit && out_free) begin
      out_data   <= uw.strobe ? 1'b0 : shreg[7];
      out_strobe <= uw.strobe;
    end
  end

  assign bits.valid       = out_valid;
  assign bits.serial_data = out_data;
  assign bits.strobe_res  = out_strobe;
  assign bits.last        = out_strobe;

  a_strobe_item: assert property (@(posedge clk) disable iff (rst)
    bits.valid && bits.strobe_res |-> bits.last && !bits.serial_data)
    else $error("strobe transfer carries data");

  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    do_flush |=> step == S_LOAD && !dirty)
    else $error("flush did not start a run");

  a_strobe_digit: assert property (@(posedge clk) disable iff (rst)
    step == S_STROBE |-> digit == '0)
    else $error("strobe before last digit");

  a_busy_no_cmd: assert property (@(posedge clk) disable iff (rst)
    step != S_IDLE |-> !cmd.ready)
    else $error("command taken during run");

endmodule
`default_nettype wire
